// ----- src/pulse_peak_rate_meter_top_macros.svh -----
// ----------------------------------------------------------------------------
// pulse_peak_rate_meter_top_macros
// assertion helpers shared by the rate meter
// ----------------------------------------------------------------------------
`ifndef PULSE_PEAK_RATE_METER_TOP_MACROS_SVH
`define PULSE_PEAK_RATE_METER_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define PPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ppr_pkg.sv -----
// ----------------------------------------------------------------------------
// ppr_pkg
// types and constants of the pulse peak rate meter
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int SAMPLE_BITS = 14;
  localparam int TIME_BITS   = 32;
  localparam int FREQ_BITS   = 20;
  localparam int BPM_BITS    = 24;

  // both quotients are worked out over the wider numerator
  localparam int QUO_BITS  = BPM_BITS;
  localparam int DIV_STEPS = QUO_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  localparam logic [QUO_BITS-1:0] FREQ_NUM = QUO_BITS'(1000000);
  localparam logic [QUO_BITS-1:0] BPM_NUM  = QUO_BITS'(15360000);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic                 accept;
    logic                 div_step;
    logic [STEP_BITS-1:0] step_idx;
    logic                 out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic beat;
    logic zero;
  } dp_status_t;

endpackage

// ----- src/ppr_if.sv -----
// ----------------------------------------------------------------------------
// ppr_if
// request channels of the pulse peak rate meter
// ----------------------------------------------------------------------------
interface ppr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [ppr_pkg::SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface ppr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           beat;
  logic [ppr_pkg::SAMPLE_BITS-1:0] peak_value;
  logic [ppr_pkg::TIME_BITS-1:0]   interval_ms;
  logic [ppr_pkg::FREQ_BITS-1:0]   freq_millihertz;
  logic [ppr_pkg::BPM_BITS-1:0]    bpm_q8;
  logic                           zero_period;

  modport source (output valid, output beat, output peak_value, output interval_ms,
                  output freq_millihertz, output bpm_q8, output zero_period,
                  input ready);
  modport sink   (input valid, input beat, input peak_value, input interval_ms,
                  input freq_millihertz, input bpm_q8, input zero_period,
                  output ready);
endinterface

// ----- src/ppr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppr_ctrl
// sequencer: takes requests, runs the divider, loads the result register
// ----------------------------------------------------------------------------
module ppr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ppr_pkg::dp_status_t status,
  output ppr_pkg::ctrl_cmd_t  cmd
);

  ppr_pkg::ctrl_state_t          state_r, state_nxt;
  logic [ppr_pkg::STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ppr_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.beat) begin
          if (status.zero) begin
            // rates saturate, nothing to divide
            state_nxt = ppr_pkg::ST_DONE;
          end else begin
            state_nxt = ppr_pkg::ST_DIV;
            cnt_nxt   = ppr_pkg::STEP_BITS'(ppr_pkg::DIV_STEPS - 1);
          end
        end
      end
      ppr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.step_idx = cnt_r;
        if (cnt_r == '0) begin
          state_nxt = ppr_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ppr_pkg::ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ppr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/ppr_dp.sv -----
// ----------------------------------------------------------------------------
// ppr_dp
// peak detector, millisecond timer, serial divider and result register
// ----------------------------------------------------------------------------
module ppr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_opcode,
  input  logic [ppr_pkg::SAMPLE_BITS-1:0] in_sample,
  input  ppr_pkg::ctrl_cmd_t              cmd,
  output ppr_pkg::dp_status_t             status,
  output logic [ppr_pkg::SAMPLE_BITS-1:0] res_peak,
  output logic [ppr_pkg::TIME_BITS-1:0]   res_period,
  output logic [ppr_pkg::FREQ_BITS-1:0]   res_freq,
  output logic [ppr_pkg::BPM_BITS-1:0]    res_bpm,
  output logic                            res_zero
);

  localparam int TB = ppr_pkg::TIME_BITS;
  localparam int QB = ppr_pkg::QUO_BITS;

  // detector and timer state
  logic                            rising_r, rising_nxt;
  logic [ppr_pkg::SAMPLE_BITS-1:0] prev_r, peak_r;
  logic [TB-1:0]                   ms_cnt_r, last_beat_r;

  // divider
  logic [TB-1:0] div_r, rem_f_r, rem_b_r;
  logic [QB-1:0] quo_f_r, quo_b_r;
  logic          zero_r;

  // result register
  logic [ppr_pkg::SAMPLE_BITS-1:0] o_peak_r;
  logic [TB-1:0]                   o_period_r;
  logic [ppr_pkg::FREQ_BITS-1:0]   o_freq_r;
  logic [ppr_pkg::BPM_BITS-1:0]    o_bpm_r;
  logic                            o_zero_r;

  logic          is_sample, rise_armed, beat_now;
  logic [TB-1:0] period;
  logic [TB:0]   trial_f, trial_b, diff_f, diff_b;

  assign is_sample  = (in_opcode == ppr_pkg::OP_SAMPLE);
  assign rise_armed = rising_r | (in_sample > prev_r);
  assign beat_now   = is_sample & rise_armed & (in_sample < prev_r);
  assign rising_nxt = beat_now ? 1'b0 : rise_armed;
  assign period     = ms_cnt_r - last_beat_r;

  assign status.beat = beat_now;
  assign status.zero = (period == '0);

  // restoring step for both numerators at once
  assign trial_f = {rem_f_r, ppr_pkg::FREQ_NUM[cmd.step_idx]};
  assign trial_b = {rem_b_r, ppr_pkg::BPM_NUM[cmd.step_idx]};
  assign diff_f  = trial_f - {1'b0, div_r};
  assign diff_b  = trial_b - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rising_r    <= 1'b0;
      prev_r      <= '0;
      peak_r      <= '0;
      ms_cnt_r    <= '0;
      last_beat_r <= '0;
    end else if (cmd.accept) begin
      if (!is_sample) begin
        ms_cnt_r <= ms_cnt_r + 1'b1;
      end else begin
        rising_r <= rising_nxt;
        prev_r   <= in_sample;
        if (beat_now) begin
          peak_r      <= prev_r;
          last_beat_r <= ms_cnt_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && beat_now) begin
      div_r      <= period;
      zero_r     <= (period == '0);
      rem_f_r    <= '0;
      rem_b_r    <= '0;
      if (period == '0) begin
        quo_f_r <= ppr_pkg::FREQ_NUM;
        quo_b_r <= ppr_pkg::BPM_NUM;
      end else begin
        quo_f_r <= '0;
        quo_b_r <= '0;
      end
    end else if (cmd.div_step) begin
      if (!diff_f[TB]) begin
        rem_f_r <= diff_f[TB-1:0];
        quo_f_r <= {quo_f_r[QB-2:0], 1'b1};
      end else begin
        rem_f_r <= trial_f[TB-1:0];
        quo_f_r <= {quo_f_r[QB-2:0], 1'b0};
      end
      if (!diff_b[TB]) begin
        rem_b_r <= diff_b[TB-1:0];
        quo_b_r <= {quo_b_r[QB-2:0], 1'b1};
      end else begin
        rem_b_r <= trial_b[TB-1:0];
        quo_b_r <= {quo_b_r[QB-2:0], 1'b0};
      end
    end
  end

  // peak and period stay in peak_r and div_r until the load
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_peak_r   <= peak_r;
      o_period_r <= div_r;
      o_freq_r   <= quo_f_r[ppr_pkg::FREQ_BITS-1:0];
      o_bpm_r    <= quo_b_r[ppr_pkg::BPM_BITS-1:0];
      o_zero_r   <= zero_r;
    end
  end

  assign res_peak   = o_peak_r;
  assign res_period = o_period_r;
  assign res_freq   = o_freq_r;
  assign res_bpm    = o_bpm_r;
  assign res_zero   = o_zero_r;

endmodule

// ----- src/pulse_peak_rate_meter_top.sv -----
// ----------------------------------------------------------------------------
// pulse_peak_rate_meter_top
// heart rate meter timing the interval between pulse peaks
// ----------------------------------------------------------------------------
// Input channel in_ch carries either a one millisecond tick or a sensor
// sample. Ticks and samples that do not complete a peak are taken one per
// cycle while no beat is in progress and give no result. A sample that
// completes a peak gives one request on out_ch with the peak value, the period
// in ms, the frequency in mHz and the rate in bpm with 8 fraction bits.
// Such a beat request runs a restoring divider, one quotient bit per cycle
// over the 24 quotient bits, both rates side by side; the result register is
// loaded once the divider is through and the register is free, and the input
// is held off until then. A beat with zero period skips the divider and is
// loaded with both rates saturated.
// The result register keeps one request while the next items are taken; if a
// second beat finishes before the first is taken, in_ch stalls until out_ch
// accepts. Synchronous reset clears the counters, the detector and out valid.
// ----------------------------------------------------------------------------
`include "pulse_peak_rate_meter_top_macros.svh"

module pulse_peak_rate_meter_top (
  input  logic       clk,
  input  logic       rst_n,
  ppr_in_if.sink     in_ch,
  ppr_out_if.source  out_ch
);

  ppr_pkg::ctrl_cmd_t  cmd;
  ppr_pkg::dp_status_t status;

  ppr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ppr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_opcode  (in_ch.opcode),
    .in_sample  (in_ch.sample_value),
    .cmd        (cmd),
    .status     (status),
    .res_peak   (out_ch.peak_value),
    .res_period (out_ch.interval_ms),
    .res_freq   (out_ch.freq_millihertz),
    .res_bpm    (out_ch.bpm_q8),
    .res_zero   (out_ch.zero_period)
  );

  assign out_ch.beat = 1'b1;

  `PPR_ASSERT_NOW(a_no_take_while_div, cmd.div_step, !in_ch.ready, "input taken during divide")
  `PPR_ASSERT_NXT(a_load_sets_valid, cmd.out_load, out_ch.valid, "result load lost")
  `PPR_ASSERT_NXT(a_beat_starts_div, cmd.accept && status.beat && !status.zero,
                  cmd.div_step, "beat did not start divider")
  `PPR_ASSERT_NXT(a_zero_skips_div, cmd.accept && status.beat && status.zero,
                  !cmd.div_step, "zero period ran divider")

endmodule

// ----- test/pulse_peak_rate_meter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_peak_rate_meter_top_tb
// self-checking bench for the pulse peak rate meter
// ----------------------------------------------------------------------------
// Sends millisecond ticks and sensor samples, tracks the peak detector and
// the millisecond counter alongside the block, and works out the period, the
// frequency and the rate of every beat. Each result request is checked field
// by field against the oldest predicted beat. Directed sequences cover zero
// periods, plateaus, sample extremes and a long interval; random traffic is
// mostly rise-then-fall shapes with random content, with noise in between.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module pulse_peak_rate_meter_top_tb;
  import ppr_pkg::*;

  localparam logic [TIME_BITS-1:0] MHZ_NUM    = TIME_BITS'(1000000);
  localparam logic [TIME_BITS-1:0] BPM_Q8_NUM = TIME_BITS'(15360000);
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef struct packed {
    logic                   beat;
    logic [SAMPLE_BITS-1:0] peak;
    logic [TIME_BITS-1:0]   period;
    logic [FREQ_BITS-1:0]   freq;
    logic [BPM_BITS-1:0]    bpm;
    logic                   zero;
  } beat_rec_t;

  logic clk = 1'b0;
  logic rst_n;

  ppr_in_if  in_ch ();
  ppr_out_if out_ch ();

  pulse_peak_rate_meter_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // detector and timing state as the block should hold it
  logic                   armed       = 1'b0;
  logic [SAMPLE_BITS-1:0] prev_sample = '0;
  logic [SAMPLE_BITS-1:0] peak_hold   = '0;
  logic [TIME_BITS-1:0]   ms_count    = '0;
  logic [TIME_BITS-1:0]   beat_time   = '0;

  beat_rec_t   pending_beats[$];
  int unsigned beats_predicted = 0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;

  // sender bursts and receiver stall pattern
  int unsigned burst_left = 0;
  bit          idle_on = 1'b1;
  bit          stall_on = 1'b1;
  logic [15:0] stall_mask = 16'hFFFF;
  int unsigned stall_pos = 0;

  task automatic track_request(input logic op, input logic [SAMPLE_BITS-1:0] smp);
    beat_rec_t            rec;
    logic                 fell;
    logic [TIME_BITS-1:0] span;
    fell = 1'b0;
    if (op == OP_TICK) begin
      ms_count = ms_count + 1'b1;
    end else begin
      if (!armed && smp > prev_sample) armed = 1'b1;
      if (armed && smp < prev_sample) begin
        peak_hold = prev_sample;
        fell      = 1'b1;
        armed     = 1'b0;
      end
      prev_sample = smp;
    end
    if (fell) begin
      span       = ms_count - beat_time;
      rec.beat   = 1'b1;
      rec.peak   = peak_hold;
      rec.period = span;
      rec.zero   = (span == '0);
      if (span == '0) begin
        rec.freq = FREQ_BITS'(MHZ_NUM);
        rec.bpm  = BPM_BITS'(BPM_Q8_NUM);
      end else begin
        rec.freq = FREQ_BITS'(MHZ_NUM / span);
        rec.bpm  = BPM_BITS'(BPM_Q8_NUM / span);
      end
      beat_time = ms_count;
      pending_beats.push_back(rec);
      beats_predicted++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) track_request(in_ch.opcode, in_ch.sample_value);
  end

  task automatic check_field(input string name, input logic [TIME_BITS-1:0] want,
                             input logic [TIME_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    beat_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: result with no beat pending, expected none, got peak %0d period %0d",
                 $time, out_ch.peak_value, out_ch.interval_ms);
      end else begin
        want = pending_beats.pop_front();
        check_field("beat", TIME_BITS'(want.beat), TIME_BITS'(out_ch.beat));
        check_field("peak_value", TIME_BITS'(want.peak), TIME_BITS'(out_ch.peak_value));
        check_field("interval_ms", want.period, out_ch.interval_ms);
        check_field("freq_millihertz", TIME_BITS'(want.freq),
                    TIME_BITS'(out_ch.freq_millihertz));
        check_field("bpm_q8", TIME_BITS'(want.bpm), TIME_BITS'(out_ch.bpm_q8));
        check_field("zero_period", TIME_BITS'(want.zero), TIME_BITS'(out_ch.zero_period));
      end
    end
  end

  // receiver ready follows a rotating mask that gets a new random value each time stall_pos wraps
  always @(posedge clk) begin
    if (stall_pos == 47) begin
      stall_mask <= ($urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom() & $urandom()))
                    | 16'h0001;
      stall_pos  <= 0;
    end else begin
      stall_pos <= stall_pos + 1;
    end
    out_ch.ready <= !stall_on || stall_mask[stall_pos % 16];
  end

  task automatic send_item(input logic op, input logic [SAMPLE_BITS-1:0] smp);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (idle_on) gap = $urandom_range(1, 5);
    end
    burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sample_value <= smp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_item(OP_TICK, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
  endtask

  task automatic test_zero_period_after_reset;
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, SAMPLE_MAX);
    send_item(OP_SAMPLE, SAMPLE_MAX);
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, SAMPLE_BITS'(1));
    send_item(OP_SAMPLE, '0);
  endtask

  // one and two millisecond periods, the second peak on a plateau
  task automatic test_short_periods;
    send_ticks(1);
    send_item(OP_SAMPLE, SAMPLE_BITS'(200));
    send_item(OP_SAMPLE, SAMPLE_BITS'(100));
    send_ticks(2);
    send_item(OP_SAMPLE, SAMPLE_BITS'(50));
    send_item(OP_SAMPLE, SAMPLE_BITS'(300));
    send_item(OP_SAMPLE, SAMPLE_BITS'(300));
    send_item(OP_SAMPLE, SAMPLE_BITS'(300));
    send_item(OP_SAMPLE, SAMPLE_BITS'(299));
  endtask

  task automatic test_sample_extremes;
    send_item(OP_SAMPLE, SAMPLE_MAX);
    send_item(OP_SAMPLE, SAMPLE_MAX - 1'b1);
    send_ticks(2);
    send_item(OP_SAMPLE, '0);
    send_item(OP_SAMPLE, SAMPLE_BITS'(8192));
    send_item(OP_SAMPLE, '0);
  endtask

  // period of a few hundred ms, sent without gaps
  task automatic test_long_interval;
    idle_on = 1'b0;
    send_item(OP_SAMPLE, SAMPLE_BITS'(100));
    send_item(OP_SAMPLE, SAMPLE_MAX);
    send_ticks(200 + $urandom_range(0, 50));
    send_item(OP_SAMPLE, SAMPLE_BITS'(50));
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic;
    int unsigned            sent_start, n_ticks, lead;
    logic [SAMPLE_BITS-1:0] lo, hi, fall_to;
    bit                     broken;
    sent_start  = items_sent;
    while (items_sent - sent_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) < 2) begin
        // noise: ticks and samples in any order
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(0, 2) == 0 ? OP_TICK : OP_SAMPLE,
                    SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    n_ticks = $urandom_range(21, 300);
          default: n_ticks = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2)
                                                         : $urandom_range(3, 20);
        endcase
        lead    = $urandom_range(0, n_ticks);
        lo      = ($urandom_range(0, 7) == 0) ? '0
                  : SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX - 1));
        hi      = ($urandom_range(0, 7) == 0) ? SAMPLE_MAX
                  : SAMPLE_BITS'($urandom_range(lo + 1, SAMPLE_MAX));
        fall_to = ($urandom_range(0, 7) == 0) ? '0
                  : SAMPLE_BITS'($urandom_range(0, hi - 1));
        broken  = ($urandom_range(0, 5) == 0);
        send_ticks(lead);
        send_item(OP_SAMPLE, lo);
        send_item(OP_SAMPLE, hi);
        repeat ($urandom_range(0, 2)) send_item(OP_SAMPLE, hi);
        send_ticks(n_ticks - lead);
        if (!broken) send_item(OP_SAMPLE, fall_to);
      end
    end
  endtask

  task automatic wait_for_results;
    int unsigned waited;
    waited = 0;
    while (pending_beats.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_SAMPLE;
    in_ch.sample_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_period_after_reset();
    test_short_periods();
    test_sample_extremes();
    test_long_interval();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    wait_for_results();
    if (pending_beats.size() != 0) begin
      errors += pending_beats.size();
      $display("%0t: %0d beats never reported", $time, pending_beats.size());
    end
    if (errors == 0) begin
      $display("pulse_peak_rate_meter_top_tb OK");
    end else begin
      $display("pulse_peak_rate_meter_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pulse_peak_rate_meter_top_tb NOT OK");
    $finish;
  end

endmodule

// ----- pulse_peak_rate_meter_top.f -----
+incdir+src
src/ppr_pkg.sv
src/ppr_if.sv
src/ppr_ctrl.sv
src/ppr_dp.sv
src/pulse_peak_rate_meter_top.sv
test/pulse_peak_rate_meter_top_tb.sv
